// File: rtl/core/ple_pkg.sv
// -----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine.
// -----------------------------------------------------------------------------
package ple_pkg;

   localparam int PLE_DEPTH = 32;
   localparam int OP_W      = 3;
   localparam int POS_W     = 6;
   localparam int VAL_W     = 32;
   localparam int ST_W      = 2;
   localparam int CNT_W     = 6;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_END   = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_END   = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_SHOW      = 3'd6,
      OP_NONE      = 3'd7
   } ple_op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } ple_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_WR,
      S_UP_FIN,
      S_DEL_OUT,
      S_DN_RD,
      S_DN_WR,
      S_SHOW
   } ple_state_type;

endpackage

// File: rtl/core/ple_mem.sv
// -----------------------------------------------------------------------------
// ple_mem
// Cell store of the list: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module ple_mem #(
   parameter int DEPTH = ple_pkg::PLE_DEPTH,
   parameter int AW    = $clog2(DEPTH),
   parameter int W     = ple_pkg::VAL_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data
);
   import ple_pkg::*;

   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data valid in the cycle after the request
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/positional_list_engine.sv
// -----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed words held in one memory, with positional insert,
// delete and a streamed listing.
// -----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req_    | in        | valid / stall    | operation, position, value
//  rsp_    | out       | valid / stall    | status, item, count, last
//
//  Rejected operations and inserts at the end load the result straight from
//  idle; a delete at the end first reads the cell, then loads it in S_DEL_OUT.
//  An insert or delete that moves cells reads and writes one moved cell at a
//  time, set by the single read and single write port of the cell memory.
//  Show streams one word per cycle while the result is free, after a cell read.
//  Reset empties the list at once; no clearing pass runs.
//  A stalled result holds the engine in idle, S_DEL_OUT and S_SHOW; the next
//  transfer is taken only in idle with the result register free or draining.
// -----------------------------------------------------------------------------
module positional_list_engine #(
   parameter int DEPTH = ple_pkg::PLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ple_pkg::OP_W-1:0]         req_operation,
   input  logic [ple_pkg::POS_W-1:0]        req_position,
   input  logic signed [ple_pkg::VAL_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ple_pkg::ST_W-1:0]         rsp_status,
   output logic signed [ple_pkg::VAL_W-1:0] rsp_item,
   output logic [ple_pkg::CNT_W-1:0]        rsp_count,
   output logic                             rsp_last
);
   import ple_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = ((FW > POS_W) ? FW : POS_W) + 1;

   ple_state_type state_ff, state_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [AW-1:0]    k_ff, k_in;
   logic [VAL_W-1:0] val_ff, val_in;

   logic             rsp_valid_ff, rsp_valid_in;
   ple_status_type   rsp_status_ff;
   logic [VAL_W-1:0] rsp_item_ff;
   logic [CW-1:0]    rsp_count_ff;
   logic             rsp_last_ff;

   logic             ld;
   ple_status_type   ld_status;
   logic [VAL_W-1:0] ld_item;
   logic [CW-1:0]    ld_count;
   logic             ld_last;

   logic             wr_en, rd_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [VAL_W-1:0] wr_data, rd_data;

   logic             out_free, accept;
   ple_op_type       op;
   logic [CW-1:0]    fill_c, pos_c, depth_c, ins_k, del_k;
   logic             is_ins, is_del, is_show;
   logic             ins_bad, del_bad, full, empty;
   logic             ins_ok, ins_shift, del_ok;
   logic             idx_at_end, dn_more;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   // decode the incoming operation against the current fill
   assign op      = ple_op_type'(req_operation);
   assign fill_c  = CW'(fill_ff);
   assign pos_c   = CW'(req_position);
   assign depth_c = CW'(DEPTH);
   assign full    = (fill_c >= depth_c);
   assign empty   = (fill_ff == '0);
   assign is_ins  = (op == OP_INS_FRONT) || (op == OP_INS_END) || (op == OP_INS_AT);
   assign is_del  = (op == OP_DEL_FRONT) || (op == OP_DEL_END) || (op == OP_DEL_AT);
   assign is_show = (op == OP_SHOW);
   assign ins_bad = (op == OP_INS_AT) && ((pos_c == '0) || (pos_c > fill_c + CW'(1)));
   assign del_bad = (op == OP_DEL_AT) && ((pos_c == '0) || (pos_c > fill_c));
   assign ins_k   = (op == OP_INS_FRONT) ? '0 :
                    (op == OP_INS_END)   ? fill_c : pos_c - CW'(1);
   assign del_k   = (op == OP_DEL_FRONT) ? '0 :
                    (op == OP_DEL_END)   ? fill_c - CW'(1) : pos_c - CW'(1);
   assign ins_ok    = is_ins && !ins_bad && !full;
   assign ins_shift = ins_ok && (ins_k != fill_c);
   assign del_ok    = is_del && !empty && !del_bad;

   assign idx_at_end = (FW'(idx_ff) == fill_ff - FW'(1));
   assign dn_more    = (FW'(idx_ff) + FW'(1) < fill_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (ins_shift) begin
                  state_in = S_UP_RD;
               end else if (del_ok) begin
                  state_in = S_DEL_OUT;
               end else if (is_show && !empty) begin
                  state_in = S_SHOW;
               end
            end
         end
         S_UP_RD:  state_in = S_UP_WR;
         S_UP_WR: begin
            state_in = (idx_ff - AW'(1) == k_ff) ? S_UP_FIN : S_UP_RD;
         end
         S_UP_FIN: state_in = S_IDLE;
         S_DEL_OUT: begin
            if (out_free) begin
               state_in = (FW'(k_ff) < fill_ff) ? S_DN_RD : S_IDLE;
            end
         end
         S_DN_RD:  state_in = S_DN_WR;
         S_DN_WR:  state_in = dn_more ? S_DN_RD : S_IDLE;
         S_SHOW: begin
            if (out_free && idx_at_end) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath controls and result loads
   always_comb begin
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      val_in    = val_ff;
      ld        = 1'b0;
      ld_status = ST_OK;
      ld_item   = '0;
      ld_count  = fill_c;
      ld_last   = 1'b1;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = val_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (is_ins) begin
                  ld = 1'b1;
                  if (ins_bad) begin
                     ld_status = ST_BADPOS;
                  end else if (full) begin
                     ld_status = ST_FULL;
                  end else begin
                     ld_count = fill_c + CW'(1);
                     fill_in  = fill_ff + FW'(1);
                     if (ins_shift) begin
                        k_in   = ins_k[AW-1:0];
                        idx_in = fill_ff[AW-1:0];
                        val_in = req_value;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = ins_k[AW-1:0];
                        wr_data = req_value;
                     end
                  end
               end else if (is_del) begin
                  if (empty) begin
                     ld        = 1'b1;
                     ld_status = ST_EMPTY;
                  end else if (del_bad) begin
                     ld        = 1'b1;
                     ld_status = ST_BADPOS;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = del_k[AW-1:0];
                     k_in    = del_k[AW-1:0];
                     idx_in  = del_k[AW-1:0];
                     fill_in = fill_ff - FW'(1);
                  end
               end else if (is_show) begin
                  if (empty) begin
                     ld        = 1'b1;
                     ld_status = ST_EMPTY;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = '0;
                     idx_in  = '0;
                  end
               end
            end
         end
         S_UP_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff - AW'(1);
         end
         S_UP_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            idx_in  = idx_ff - AW'(1);
         end
         S_UP_FIN: begin
            wr_en   = 1'b1;
            wr_addr = k_ff;
         end
         S_DEL_OUT: begin
            if (out_free) begin
               ld      = 1'b1;
               ld_item = rd_data;
            end
         end
         S_DN_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff + AW'(1);
         end
         S_DN_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            idx_in  = idx_ff + AW'(1);
         end
         S_SHOW: begin
            if (out_free) begin
               ld      = 1'b1;
               ld_item = rd_data;
               ld_last = idx_at_end;
               if (!idx_at_end) begin
                  idx_in  = idx_ff + AW'(1);
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + AW'(1);
               end
            end
         end
         default: begin
            ld = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = ld ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      k_ff   <= k_in;
      val_ff <= val_in;
      if (ld) begin
         rsp_status_ff <= ld_status;
         rsp_item_ff   <= ld_item;
         rsp_count_ff  <= ld_count;
         rsp_last_ff   <= ld_last;
      end
   end

   ple_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .W     (VAL_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_item   = rsp_item_ff;
   assign rsp_count  = CNT_W'(rsp_count_ff);
   assign rsp_last   = rsp_last_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(fill_ff) <= depth_c)
      else $error("fill above depth");

   a_up_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UP_WR |-> idx_ff > k_ff)
      else $error("upward shift passed its target");

   a_dn_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DN_WR |-> FW'(idx_ff) < fill_ff)
      else $error("downward shift beyond fill");

endmodule

// File: bench/tb_positional_list_engine.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking bench for the positional list engine: a directed table of
// list operations, random fill/drain traffic and a full-list pass, every result
// compared with a local list predictor, with random idling on both channels.
// -----------------------------------------------------------------------------
module tb_positional_list_engine;
   import ple_pkg::*;

   localparam int DEPTH     = PLE_DEPTH;
   localparam int N_RANDOM  = 100;
   localparam int CYC_LIMIT = 400000;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic signed [VAL_W-1:0] item;
      logic [CNT_W-1:0]        count;
      logic                    last;
   } list_rsp_type;

   typedef struct {
      ple_op_type              op;
      logic [POS_W-1:0]        pos;
      logic signed [VAL_W-1:0] val;
      bit                      typed;
      list_rsp_type            want;
   } dir_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [OP_W-1:0]         req_operation = '0;
   logic [POS_W-1:0]        req_position = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [ST_W-1:0]         rsp_status;
   logic signed [VAL_W-1:0] rsp_item;
   logic [CNT_W-1:0]        rsp_count;
   logic                    rsp_last;

   // predictor state
   logic signed [VAL_W-1:0] list_words[$];
   list_rsp_type            pending_rsp[$];

   int  mismatches = 0;
   int  rsp_seen   = 0;
   int  items_sent = 0;
   int  cycles     = 0;
   bit  calm       = 1'b0;

   positional_list_engine dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYC_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL positional_list_engine");
         $finish;
      end
   end

   function automatic list_rsp_type mk_rsp(ple_status_type s, logic signed [VAL_W-1:0] w,
                                           int n, bit l);
      list_rsp_type r;
      r.status = s;
      r.item   = w;
      r.count  = n[CNT_W-1:0];
      r.last   = l;
      return r;
   endfunction

   // apply one operation to the list copy and queue its expected results
   task automatic predict_list_op(ple_op_type op, int pos, logic signed [VAL_W-1:0] val);
      int n;
      logic signed [VAL_W-1:0] w;
      n = list_words.size();
      case (op)
         OP_INS_FRONT, OP_INS_END: begin
            if (n >= DEPTH) pending_rsp.push_back(mk_rsp(ST_FULL, 0, n, 1));
            else begin
               if (op == OP_INS_FRONT) list_words.push_front(val);
               else list_words.push_back(val);
               pending_rsp.push_back(mk_rsp(ST_OK, 0, n + 1, 1));
            end
         end
         OP_INS_AT: begin
            if (pos < 1 || pos > n + 1) pending_rsp.push_back(mk_rsp(ST_BADPOS, 0, n, 1));
            else if (n >= DEPTH) pending_rsp.push_back(mk_rsp(ST_FULL, 0, n, 1));
            else begin
               list_words.insert(pos - 1, val);
               pending_rsp.push_back(mk_rsp(ST_OK, 0, n + 1, 1));
            end
         end
         OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
            if (n == 0) pending_rsp.push_back(mk_rsp(ST_EMPTY, 0, 0, 1));
            else if (op == OP_DEL_AT && (pos < 1 || pos > n))
               pending_rsp.push_back(mk_rsp(ST_BADPOS, 0, n, 1));
            else begin
               if (op == OP_DEL_FRONT) w = list_words.pop_front();
               else if (op == OP_DEL_END) w = list_words.pop_back();
               else begin
                  w = list_words[pos - 1];
                  list_words.delete(pos - 1);
               end
               pending_rsp.push_back(mk_rsp(ST_OK, w, n - 1, 1));
            end
         end
         OP_SHOW: begin
            if (n == 0) pending_rsp.push_back(mk_rsp(ST_EMPTY, 0, 0, 1));
            else for (int i = 0; i < n; i++)
               pending_rsp.push_back(mk_rsp(ST_OK, list_words[i], n, i == n - 1));
         end
         default: ;
      endcase
   endtask

   // drive one request and wait for its transfer
   task automatic send_req(ple_op_type op, int pos, logic signed [VAL_W-1:0] val);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_position  <= pos[POS_W-1:0];
      req_value     <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // result side: random stall, compare each transfer with the oldest expectation
   always @(posedge clock) begin
      list_rsp_type got, exp_r;
      if (!reset) begin
         rsp_stall <= !calm && ($urandom_range(99) < 7);
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_item, rsp_count, rsp_last};
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               exp_r = pending_rsp.pop_front();
               if (got !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp st=%0d item=%0d cnt=%0d last=%0b,",
                               " got st=%0d item=%0d cnt=%0d last=%0b"},
                              exp_r.status, exp_r.item, exp_r.count, exp_r.last,
                              got.status, got.item, got.count, got.last);
               end
            end
         end
      end
   end

   dir_row_type dir_table[$];

   function automatic dir_row_type row(ple_op_type op, int pos, logic signed [VAL_W-1:0] val,
                                       bit typed, list_rsp_type want);
      dir_row_type r;
      r.op = op; r.pos = pos[POS_W-1:0]; r.val = val; r.typed = typed; r.want = want;
      return r;
   endfunction

   initial begin
      ple_op_type op;
      int pos, n, roll, wait_cyc;
      logic signed [VAL_W-1:0] val;
      list_rsp_type none;
      none = '0;

      // directed: empty cases, extremes, bad positions, every operation
      dir_table.push_back(row(OP_DEL_FRONT, 0, 0, 1, mk_rsp(ST_EMPTY, 0, 0, 1)));
      dir_table.push_back(row(OP_DEL_END, 0, 0, 1, mk_rsp(ST_EMPTY, 0, 0, 1)));
      dir_table.push_back(row(OP_DEL_AT, 1, 0, 1, mk_rsp(ST_EMPTY, 0, 0, 1)));
      dir_table.push_back(row(OP_SHOW, 0, 0, 1, mk_rsp(ST_EMPTY, 0, 0, 1)));
      dir_table.push_back(row(OP_INS_AT, 0, 5, 1, mk_rsp(ST_BADPOS, 0, 0, 1)));
      dir_table.push_back(row(OP_INS_AT, 2, 5, 1, mk_rsp(ST_BADPOS, 0, 0, 1)));
      dir_table.push_back(row(OP_INS_FRONT, 63, 32'sh7FFFFFFF, 1, mk_rsp(ST_OK, 0, 1, 1)));
      dir_table.push_back(row(OP_DEL_AT, 1, 0, 1, mk_rsp(ST_OK, 32'sh7FFFFFFF, 0, 1)));
      dir_table.push_back(row(OP_INS_END, 0, 32'sh80000000, 1, mk_rsp(ST_OK, 0, 1, 1)));
      dir_table.push_back(row(OP_INS_AT, 1, -1, 1, mk_rsp(ST_OK, 0, 2, 1)));
      dir_table.push_back(row(OP_INS_AT, 3, 32'h55555555, 1, mk_rsp(ST_OK, 0, 3, 1)));
      dir_table.push_back(row(OP_INS_AT, 2, 32'h2AAAAAAA, 0, none));
      dir_table.push_back(row(OP_DEL_AT, 0, 0, 1, mk_rsp(ST_BADPOS, 0, 4, 1)));
      dir_table.push_back(row(OP_DEL_AT, 5, 0, 1, mk_rsp(ST_BADPOS, 0, 4, 1)));
      dir_table.push_back(row(OP_NONE, 33, 7, 0, none));
      dir_table.push_back(row(OP_SHOW, 0, 0, 0, none));
      dir_table.push_back(row(OP_DEL_AT, 2, 0, 0, none));
      dir_table.push_back(row(OP_DEL_END, 0, 0, 0, none));
      dir_table.push_back(row(OP_DEL_FRONT, 0, 0, 0, none));
      dir_table.push_back(row(OP_SHOW, 0, 0, 0, none));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) begin
         if (dir_table[i].typed) begin
            predict_list_op(dir_table[i].op, dir_table[i].pos, dir_table[i].val);
            void'(pending_rsp.pop_back());
            pending_rsp.push_back(dir_table[i].want);
         end else
            predict_list_op(dir_table[i].op, dir_table[i].pos, dir_table[i].val);
         send_req(dir_table[i].op, dir_table[i].pos, dir_table[i].val);
      end

      // random: alternate fill-heavy and drain-heavy phases to reach full and empty
      for (int k = 0; k < N_RANDOM; k++) begin
         calm = (k >= 60 && k < 90);
         n = list_words.size();
         roll = $urandom_range(99);
         if ((k / 40) % 2 == 0) begin
            if (roll < 30) op = OP_INS_FRONT;
            else if (roll < 55) op = OP_INS_END;
            else if (roll < 82) op = OP_INS_AT;
            else if (roll < 88) op = OP_DEL_AT;
            else if (roll < 95) op = OP_SHOW;
            else op = ple_op_type'($urandom_range(7));
         end else begin
            if (roll < 20) op = OP_DEL_FRONT;
            else if (roll < 40) op = OP_DEL_END;
            else if (roll < 70) op = OP_DEL_AT;
            else if (roll < 80) op = OP_INS_AT;
            else if (roll < 90) op = OP_SHOW;
            else op = ple_op_type'($urandom_range(7));
         end
         if ($urandom_range(9) == 0) pos = $urandom_range(63);
         else pos = $urandom_range(n + 1);
         val = $urandom;
         predict_list_op(op, pos, val);
         send_req(op, pos, val);
      end
      calm = 1'b0;
      // a full list for the full cases
      while (list_words.size() < DEPTH) begin
         val = $urandom;
         predict_list_op(OP_INS_END, 0, val);
         send_req(OP_INS_END, 0, val);
      end
      for (int k = 0; k < 3; k++) begin
         op = ple_op_type'(k);
         predict_list_op(op, 1, -7);
         send_req(op, 1, -7);
      end
      predict_list_op(OP_SHOW, 0, 0);
      send_req(OP_SHOW, 0, 0);
      predict_list_op(OP_DEL_AT, DEPTH, 0);
      send_req(OP_DEL_AT, DEPTH, 0);
      req_valid <= 1'b0;

      // drain
      while (pending_rsp.size() != 0) @(posedge clock);
      wait_cyc = 0;
      while (wait_cyc < 4 * DEPTH + 20) begin
         @(posedge clock);
         wait_cyc++;
      end
      $display("sent %0d requests, checked %0d results", items_sent, rsp_seen);
      $display("covered empty, full and bad-position cases under random stalls");
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("PASS positional_list_engine");
      else
         $display("FAIL positional_list_engine");
      $finish;
   end

endmodule
